[design/lsc_pkg.sv]
// shared types and constants for the line separation checker
`default_nettype none

package lsc_pkg;

    localparam int MAX_POINTS_DEF = 1024;
    localparam int QUEUE_DEPTH    = 4;

    localparam int COORD_W = 16;
    localparam int LINE_W  = 24;
    localparam int PROD_W  = COORD_W + LINE_W;
    localparam int VAL_W   = PROD_W + 2;
    localparam int ENTRY_W = 2 * COORD_W + 1;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_LOAD  = 2'd1,
        OP_QUERY = 2'd2,
        OP_RSVD  = 2'd3
    } op_t;

    typedef struct packed {
        op_t                        kind;
        logic signed [COORD_W-1:0]  x;
        logic signed [COORD_W-1:0]  y;
        logic                       cls;
        logic signed [LINE_W-1:0]   bias;
        logic signed [LINE_W-1:0]   wx;
        logic signed [LINE_W-1:0]   wy;
    } cmd_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_WALK,
        BK_FLUSH
    } bk_state_t;

endpackage

`default_nettype wire

[design/lsc_front.sv]
// front end: takes items, drops unused codes, packs commands for the queue
`default_nettype none

module lsc_front (
    input  wire logic                               start,
    input  wire logic                               q_full,
    input  wire logic [1:0]                         op,
    input  wire logic signed [lsc_pkg::COORD_W-1:0] point_x,
    input  wire logic signed [lsc_pkg::COORD_W-1:0] point_y,
    input  wire logic                               point_class,
    input  wire logic signed [lsc_pkg::LINE_W-1:0]  line_bias,
    input  wire logic signed [lsc_pkg::LINE_W-1:0]  line_wx,
    input  wire logic signed [lsc_pkg::LINE_W-1:0]  line_wy,
    output lsc_pkg::cmd_t                           push_data,
    output logic                                    push
);
    import lsc_pkg::*;

    logic known_op;

    always_comb
    begin
        unique case (op_t'(op))
            OP_CLEAR, OP_LOAD, OP_QUERY: known_op = 1'b1;
            default:                     known_op = 1'b0;
        endcase
    end

    assign push = start && !q_full && known_op;

    always_comb
    begin
        push_data.kind = op_t'(op);
        push_data.x    = point_x;
        push_data.y    = point_y;
        push_data.cls  = point_class;
        push_data.bias = line_bias;
        push_data.wx   = line_wx;
        push_data.wy   = line_wy;
    end

endmodule

`default_nettype wire

[design/lsc_queue.sv]
// short command queue between front and back
`default_nettype none

module lsc_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  lsc_pkg::cmd_t      push_data,
    input  wire logic          pop,
    output lsc_pkg::cmd_t      pop_data,
    output logic               full,
    output logic               empty
);
    import lsc_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] fill_reg, fill_next;

    assign full     = (fill_reg == CNT_W'(QUEUE_DEPTH));
    assign empty    = (fill_reg == '0);
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

[design/lsc_back.sv]
// back end: point store, query walk with multiply and min/max pipeline
`default_nettype none

module lsc_back #(
    parameter int MAX_POINTS = lsc_pkg::MAX_POINTS_DEF
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     q_empty,
    input  lsc_pkg::cmd_t cmd,
    output logic          pop,
    output logic          done,
    output logic          separable,
    output logic          class_missing
);
    import lsc_pkg::*;

    localparam int ADDR_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);

    bk_state_t state_reg, state_next;

    logic [ENTRY_W-1:0] point_mem [MAX_POINTS];
    logic [ENTRY_W-1:0] rd_data_reg;

    logic [CNT_W-1:0]  count_reg;
    logic [ADDR_W-1:0] idx_reg;

    logic signed [LINE_W-1:0] bias_reg, wx_reg, wy_reg;

    logic                     s1_v_reg, s2_v_reg, s3_v_reg;
    logic                     s2_cls_reg, s3_cls_reg;
    logic signed [PROD_W-1:0] prod_x_reg, prod_y_reg;
    logic signed [VAL_W-1:0]  sum_reg;

    logic [1:0]               has_reg;
    logic signed [VAL_W-1:0]  lo_reg [2];
    logic signed [VAL_W-1:0]  hi_reg [2];

    logic rd_en, last_issue, pipe_empty, finish, store_full;
    logic pop_clear, pop_load, pop_query;
    logic sep_comb, missing_comb;

    assign last_issue = ((CNT_W'(idx_reg) + 1'b1) == count_reg);
    assign pipe_empty = !s1_v_reg && !s2_v_reg && !s3_v_reg;
    assign store_full = (count_reg >= CNT_W'(MAX_POINTS));
    assign pop_clear  = pop && (cmd.kind == OP_CLEAR);
    assign pop_load   = pop && (cmd.kind == OP_LOAD);
    assign pop_query  = pop && (cmd.kind == OP_QUERY);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty && (cmd.kind == OP_QUERY))
                begin
                    state_next = (count_reg == '0) ? BK_FLUSH : BK_WALK;
                end
            end
            BK_WALK:
            begin
                if (last_issue)
                begin
                    state_next = BK_FLUSH;
                end
            end
            BK_FLUSH:
            begin
                if (pipe_empty)
                begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        pop    = 1'b0;
        rd_en  = 1'b0;
        finish = 1'b0;
        unique case (state_reg)
            BK_IDLE:  pop    = !q_empty;
            BK_WALK:  rd_en  = 1'b1;
            BK_FLUSH: finish = pipe_empty;
            default:  pop    = 1'b0;
        endcase
    end

    assign missing_comb = !(has_reg[0] && has_reg[1]);
    assign sep_comb     = !missing_comb
                          && (((lo_reg[0] > 0) && (hi_reg[1] < 0))
                              || ((lo_reg[1] > 0) && (hi_reg[0] < 0)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            count_reg <= '0;
            idx_reg   <= '0;
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            s3_v_reg  <= 1'b0;
            has_reg   <= '0;
            done      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            s1_v_reg  <= rd_en;
            s2_v_reg  <= s1_v_reg;
            s3_v_reg  <= s2_v_reg;
            done      <= finish;
            if (pop_clear)
            begin
                count_reg <= '0;
            end
            else if (pop_load && !store_full)
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (pop_query)
            begin
                idx_reg <= '0;
            end
            else if (rd_en)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (pop_query)
            begin
                has_reg <= '0;
            end
            else if (s3_v_reg)
            begin
                has_reg[s3_cls_reg] <= 1'b1;
            end
        end
    end

    // point store
    always_ff @(posedge clk)
    begin
        if (pop_load && !store_full)
        begin
            point_mem[count_reg[ADDR_W-1:0]] <= {cmd.cls, cmd.y, cmd.x};
        end
        if (rd_en)
        begin
            rd_data_reg <= point_mem[idx_reg];
        end
    end

    // line evaluation and per-class extremes
    always_ff @(posedge clk)
    begin
        if (pop_query)
        begin
            bias_reg <= cmd.bias;
            wx_reg   <= cmd.wx;
            wy_reg   <= cmd.wy;
        end
        prod_x_reg <= PROD_W'(wx_reg * $signed(rd_data_reg[COORD_W-1:0]));
        prod_y_reg <= PROD_W'(wy_reg * $signed(rd_data_reg[2*COORD_W-1:COORD_W]));
        s2_cls_reg <= rd_data_reg[ENTRY_W-1];
        sum_reg    <= VAL_W'(bias_reg) + VAL_W'(prod_x_reg) + VAL_W'(prod_y_reg);
        s3_cls_reg <= s2_cls_reg;
        for (int c = 0; c < 2; c++)
        begin
            if (s3_v_reg && (s3_cls_reg == 1'(c)))
            begin
                if (!has_reg[c] || (sum_reg < lo_reg[c]))
                begin
                    lo_reg[c] <= sum_reg;
                end
                if (!has_reg[c] || (sum_reg > hi_reg[c]))
                begin
                    hi_reg[c] <= sum_reg;
                end
            end
        end
        if (finish)
        begin
            separable     <= sep_comb;
            class_missing <= missing_comb;
        end
    end

endmodule

`default_nettype wire

[design/line_separates_two_point_classes_core.sv]
// top level of the line separation checker
`default_nettype none

// usage:
//   command channel: an item (op and its fields) transfers at a clock edge with
//   start high and busy low. op selects clear, load one point or query a line;
//   the unused op code is dropped without a result.
//   result channel: each query gives one result, shown on separable and
//   class_missing for exactly one cycle while done is high. the receiver has no
//   way to stall, so results are simply presented.
//   commands wait in a four-entry queue; busy is high only while it is full.
//   a clear or load is popped as soon as it reaches the head with the back end idle.
//   a query walks every stored point in the back end, then drains the pipeline
//   (only the drain with the store empty), and the result strobe follows in
//   the next cycle: one point read from the store per cycle through a read,
//   multiply, sum and min/max pipeline. sustained rate is set by that single
//   store read port; no new command is taken until the query has finished.
//   reset clears the point count, the queue and the strobe; store contents are
//   left as they are and never read before being written.

module line_separates_two_point_classes_core #(
    parameter int MAX_POINTS = lsc_pkg::MAX_POINTS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic [1:0]                         op,
    input  wire logic signed [lsc_pkg::COORD_W-1:0] point_x,
    input  wire logic signed [lsc_pkg::COORD_W-1:0] point_y,
    input  wire logic                               point_class,
    input  wire logic signed [lsc_pkg::LINE_W-1:0]  line_bias,
    input  wire logic signed [lsc_pkg::LINE_W-1:0]  line_wx,
    input  wire logic signed [lsc_pkg::LINE_W-1:0]  line_wy,
    output logic                                    done,
    output logic                                    separable,
    output logic                                    class_missing
);
    import lsc_pkg::*;

    cmd_t push_data, pop_data;
    logic push, pop, q_full, q_empty;

    assign busy = q_full;

    lsc_front u_front (
        .start       (start),
        .q_full      (q_full),
        .op          (op),
        .point_x     (point_x),
        .point_y     (point_y),
        .point_class (point_class),
        .line_bias   (line_bias),
        .line_wx     (line_wx),
        .line_wy     (line_wy),
        .push_data   (push_data),
        .push        (push)
    );

    lsc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    lsc_back #(
        .MAX_POINTS (MAX_POINTS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .cmd           (pop_data),
        .pop           (pop),
        .done          (done),
        .separable     (separable),
        .class_missing (class_missing)
    );

endmodule

`default_nettype wire

[design/lsc_checker.sv]
// port checker for the line separation checker, bound to the top level
`default_nettype none

module lsc_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic done,
    input wire logic separable,
    input wire logic class_missing
);

    // strobe is low while reset is held
    a_no_done_in_reset: assert property (@(posedge clk) !rst_n |-> !done)
        else $error("result strobe during reset");

    // a query ends in the flush state and the back end then returns to idle, so strobes never come back to back
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobes in consecutive cycles");

    // a missing class can never be separated
    a_missing_not_sep: assert property (@(posedge clk) disable iff (!rst_n)
        (done && class_missing) |-> !separable)
        else $error("separable reported with a class missing");

    // the queue only fills on a transfer
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without a command transfer");

endmodule

bind line_separates_two_point_classes_core lsc_checker u_lsc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .done          (done),
    .separable     (separable),
    .class_missing (class_missing)
);

`default_nettype wire

[sim/line_separates_two_point_classes_core_test.sv]
// testbench for the line separation checker: random point sets and lines, checked per query
`default_nettype none

module line_separates_two_point_classes_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import lsc_pkg::*;

    localparam int STALL_LIMIT = 12000;
    localparam int DRAIN_CYCLES = 40;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [LINE_W-1:0] coef_t;

    typedef struct packed {
        logic sep;
        logic missing;
    } verdict_t;

    class separation_scoreboard;
        coord_t     px [MAX_POINTS_DEF];
        coord_t     py [MAX_POINTS_DEF];
        bit         pc [MAX_POINTS_DEF];
        int         npoints;
        verdict_t   verdicts_due [$];
        int         mismatches;

        function new();
            npoints = 0;
            mismatches = 0;
        endfunction

        function longint line_value(coef_t b, coef_t w1, coef_t w2, coord_t x, coord_t y);
            return longint'(b) + longint'(w1) * longint'(x) + longint'(w2) * longint'(y);
        endfunction

        function void note_command(cmd_t c);
            bit       seen [2];
            longint   lo [2];
            longint   hi [2];
            longint   v;
            int       k;
            verdict_t vd;
            case (c.kind)
                OP_CLEAR: npoints = 0;
                OP_LOAD:
                begin
                    if (npoints < MAX_POINTS_DEF)
                    begin
                        px[npoints] = c.x;
                        py[npoints] = c.y;
                        pc[npoints] = c.cls;
                        npoints++;
                    end
                end
                OP_QUERY:
                begin
                    seen[0] = 1'b0;
                    seen[1] = 1'b0;
                    lo[0] = 0;
                    lo[1] = 0;
                    hi[0] = 0;
                    hi[1] = 0;
                    for (int i = 0; i < npoints; i++)
                    begin
                        v = line_value(c.bias, c.wx, c.wy, px[i], py[i]);
                        k = int'(pc[i]);
                        if (!seen[k])
                        begin
                            seen[k] = 1'b1;
                            lo[k] = v;
                            hi[k] = v;
                        end
                        else
                        begin
                            if (v < lo[k])
                                lo[k] = v;
                            if (v > hi[k])
                                hi[k] = v;
                        end
                    end
                    vd.missing = !(seen[0] && seen[1]);
                    vd.sep = !vd.missing
                        && ((lo[0] > 0 && hi[1] < 0) || (lo[1] > 0 && hi[0] < 0));
                    verdicts_due.push_back(vd);
                end
                default: ;
            endcase
        endfunction

        function void check_result(logic sep, logic missing);
            verdict_t vd;
            if (verdicts_due.size() == 0)
            begin
                $display("%0t: result with no query pending: separable %b class_missing %b",
                    $time, sep, missing);
                mismatches++;
                return;
            end
            vd = verdicts_due.pop_front();
            if (sep !== vd.sep)
            begin
                $display("%0t: separable expected %b got %b", $time, vd.sep, sep);
                mismatches++;
            end
            if (missing !== vd.missing)
            begin
                $display("%0t: class_missing expected %b got %b", $time, vd.missing, missing);
                mismatches++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  op;
    coord_t      point_x;
    coord_t      point_y;
    logic        point_class;
    coef_t       line_bias;
    coef_t       line_wx;
    coef_t       line_wy;
    logic        done;
    logic        separable;
    logic        class_missing;

    separation_scoreboard sb = new();
    int idle_pct;
    int items_sent;
    int stall_cycles;

    line_separates_two_point_classes_core #(
        .MAX_POINTS(MAX_POINTS_DEF)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .op(op),
        .point_x(point_x),
        .point_y(point_y),
        .point_class(point_class),
        .line_bias(line_bias),
        .line_wx(line_wx),
        .line_wy(line_wy),
        .done(done),
        .separable(separable),
        .class_missing(class_missing)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // result check and watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((start === 1'b1 && busy === 1'b0) || done === 1'b1 || rst_n !== 1'b1)
            stall_cycles = 0;
        else
            stall_cycles++;
        if (rst_n === 1'b1 && done === 1'b1)
            sb.check_result(separable, class_missing);
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic coord_t pick_coord();
        case ($urandom_range(7))
            0: return {1'b1, {(COORD_W-1){1'b0}}};
            1: return {1'b0, {(COORD_W-1){1'b1}}};
            2: return COORD_W'(int'($urandom_range(16)) - 8);
            default: return COORD_W'($urandom);
        endcase
    endfunction

    function automatic coef_t pick_coef();
        case ($urandom_range(7))
            0: return {1'b1, {(LINE_W-1){1'b0}}};
            1: return {1'b0, {(LINE_W-1){1'b1}}};
            2: return LINE_W'(int'($urandom_range(16)) - 8);
            default: return LINE_W'($urandom);
        endcase
    endfunction

    function automatic cmd_t random_cmd(op_t kind);
        cmd_t c;
        c.kind = kind;
        c.x = pick_coord();
        c.y = pick_coord();
        c.cls = 1'($urandom_range(1));
        c.bias = pick_coef();
        c.wx = pick_coef();
        c.wy = pick_coef();
        return c;
    endfunction

    function automatic cmd_t make_cmd(op_t kind, coord_t x, coord_t y, bit cls,
                                      coef_t b, coef_t w1, coef_t w2);
        cmd_t c;
        c = random_cmd(kind);
        if (kind == OP_LOAD)
        begin
            c.x = x;
            c.y = y;
            c.cls = cls;
        end
        if (kind == OP_QUERY)
        begin
            c.bias = b;
            c.wx = w1;
            c.wy = w2;
        end
        return c;
    endfunction

    task automatic send_item(cmd_t c);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        op <= c.kind;
        point_x <= c.x;
        point_y <= c.y;
        point_class <= c.cls;
        line_bias <= c.bias;
        line_wx <= c.wx;
        line_wy <= c.wy;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        sb.note_command(c);
        items_sent++;
    endtask

    // point classed by its side of the planned line, sometimes on the wrong side
    task automatic load_classified(cmd_t plan, bit flip, int wrong_pct);
        cmd_t   c;
        longint v;
        c = random_cmd(OP_LOAD);
        v = sb.line_value(plan.bias, plan.wx, plan.wy, c.x, c.y);
        if (v != 0)
            c.cls = (v < 0) ^ flip;
        if ($urandom_range(99) < wrong_pct)
            c.cls = ~c.cls;
        send_item(c);
    endtask

    task automatic run_sequence(int n);
        cmd_t plan;
        cmd_t c;
        bit   flip;
        if ($urandom_range(3) != 0 || sb.npoints > 60)
            send_item(random_cmd(OP_CLEAR));
        plan = random_cmd(OP_QUERY);
        flip = 1'($urandom_range(1));
        repeat (n)
            load_classified(plan, flip, 8);
        send_item(plan);
        repeat ($urandom_range(2))
        begin
            c = random_cmd(OP_QUERY);
            if ($urandom_range(1))
            begin
                c.wx = plan.wx;
                c.wy = plan.wy;
            end
            send_item(c);
        end
    endtask

    task automatic run_random(int target);
        while (items_sent < target)
        begin
            if ($urandom_range(99) < 8)
                send_item(random_cmd(op_t'($urandom_range(3))));
            else
                run_sequence($urandom_range(12));
        end
    endtask

    task automatic run_directed();
        send_item(random_cmd(OP_CLEAR));
        send_item(make_cmd(OP_QUERY, 0, 0, 0, 1, 1, 1));
        send_item(make_cmd(OP_LOAD, 16'sh7fff, 16'sh7fff, 0, 0, 0, 0));
        send_item(make_cmd(OP_QUERY, 0, 0, 0, 0, 1, 1));
        send_item(make_cmd(OP_LOAD, 16'sh8000, 16'sh8000, 1, 0, 0, 0));
        send_item(make_cmd(OP_QUERY, 0, 0, 0, 0, 24'sh7fffff, 24'sh7fffff));
        send_item(make_cmd(OP_QUERY, 0, 0, 0, 24'sh800000, 24'sh800000, 24'sh800000));
        send_item(make_cmd(OP_QUERY, 0, 0, 0, 24'sh7fffff, 0, 0));
        send_item(make_cmd(OP_QUERY, 0, 0, 0, 24'sh7fffff, 24'sh800000, 24'sh7fffff));
        // point exactly on the line
        send_item(make_cmd(OP_LOAD, 0, 0, 0, 0, 0, 0));
        send_item(make_cmd(OP_QUERY, 0, 0, 0, 0, 1, 1));
        send_item(make_cmd(OP_QUERY, 0, 0, 0, 1, 1, 1));
        send_item(random_cmd(OP_RSVD));
        send_item(make_cmd(OP_QUERY, 0, 0, 0, 0, 0, 0));
        send_item(random_cmd(OP_CLEAR));
        send_item(make_cmd(OP_QUERY, 0, 0, 0, 5, 1, 1));
        send_item(make_cmd(OP_LOAD, -1, 16'sh7fff, 1, 0, 0, 0));
        send_item(make_cmd(OP_LOAD, 16'sh7fff, 16'sh8000, 0, 0, 0, 0));
        send_item(make_cmd(OP_QUERY, 0, 0, 0, -1, 24'sh800000, 24'sh7fffff));
        send_item(make_cmd(OP_QUERY, 0, 0, 0, 24'sh800000, 24'sh7fffff, 24'sh800000));
        send_item(make_cmd(OP_QUERY, 0, 0, 0, 24'sh7fffff, 24'sh7fffff, 24'sh800000));
    endtask

    initial
    begin
        rst_n <= 1'b0;
        start <= 1'b0;
        op <= OP_CLEAR;
        point_x <= '0;
        point_y <= '0;
        point_class <= 1'b0;
        line_bias <= '0;
        line_wx <= '0;
        line_wy <= '0;
        idle_pct = 8;
        items_sent = 0;
        stall_cycles = 0;
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        run_random(items_sent + 220);
        idle_pct = 79;
        run_random(items_sent + 160);
        idle_pct = 0;
        run_random(items_sent + 180);
        start <= 1'b0;

        while (sb.verdicts_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (sb.mismatches == 0 && sb.verdicts_due.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire
